// ----- rtl/hill_cipher_2x2_stream_defines.svh -----
// Assertion macros for the Hill cipher checker.
`ifndef HILL_CIPHER_2X2_STREAM_DEFINES_SVH
`define HILL_CIPHER_2X2_STREAM_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define HC2_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hc2 assertion failed");

// Clocked assertion that also holds while reset is held.
`define HC2_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("hc2 assertion failed");

`endif

// ----- rtl/hc2_pkg.sv -----
// Shared types, constants and mod-26 helper functions for the Hill cipher stream.
package hc2_pkg;

    localparam int unsigned Modulus    = 26;
    localparam int unsigned LetterBase = 97;
    localparam int unsigned ModMul     = 315;
    localparam int unsigned ModShift   = 13;
    localparam int unsigned KeyLatency = 5;
    localparam int unsigned KeyLatW    = $clog2(KeyLatency + 1);
    localparam int unsigned QDepth     = 4;
    localparam int unsigned QPtrW      = $clog2(QDepth);
    localparam int unsigned QCntW      = $clog2(QDepth + 1);
    localparam int unsigned AddrW      = 5;
    localparam int unsigned RegIdxW    = AddrW - 2;
    localparam int unsigned DataW      = 32;

    localparam logic [7:0] UpperA = 8'h41;
    localparam logic [7:0] UpperZ = 8'h5A;
    localparam logic [7:0] LowerA = 8'h61;
    localparam logic [7:0] LowerZ = 8'h7A;

    localparam logic [RegIdxW-1:0] RegKeyA11    = RegIdxW'(0);
    localparam logic [RegIdxW-1:0] RegKeyA12    = RegIdxW'(1);
    localparam logic [RegIdxW-1:0] RegKeyA21    = RegIdxW'(2);
    localparam logic [RegIdxW-1:0] RegKeyA22    = RegIdxW'(3);
    localparam logic [RegIdxW-1:0] RegDirection = RegIdxW'(4);
    localparam logic [RegIdxW-1:0] RegPadLetter = RegIdxW'(5);

    typedef logic [4:0] t_letter;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [6:0] out_letter;
        logic       pair_last;
        logic       text_done;
    } t_out_item;

    typedef struct packed {
        t_letter p1;
        t_letter p2;
        logic    last;
    } t_pair;

    typedef struct packed {
        t_letter m11;
        t_letter m12;
        t_letter m21;
        t_letter m22;
        t_letter pad;
    } t_key;

    function automatic t_letter f_red26(input t_letter v);
        return (v >= 5'(Modulus)) ? 5'(v - 5'(Modulus)) : v;
    endfunction

    function automatic t_letter f_neg26(input t_letter v);
        return (v == '0) ? '0 : 5'(5'(Modulus) - v);
    endfunction

    function automatic t_letter f_mod26(input logic [10:0] x);
        logic [19:0] prod;
        logic [6:0]  quo;
        logic [11:0] rem;
        prod = 20'(x) * 20'(ModMul);
        quo  = 7'(prod >> ModShift);
        rem  = 12'(x) - 12'(quo) * 12'(Modulus);
        if (rem >= 12'(Modulus)) begin
            rem = rem - 12'(Modulus);
        end
        return rem[4:0];
    endfunction

    function automatic t_letter f_inv26(input t_letter det);
        t_letter inv;
        case (det)
            5'd1:    inv = 5'd1;
            5'd3:    inv = 5'd9;
            5'd5:    inv = 5'd21;
            5'd7:    inv = 5'd15;
            5'd9:    inv = 5'd3;
            5'd11:   inv = 5'd19;
            5'd15:   inv = 5'd7;
            5'd17:   inv = 5'd23;
            5'd19:   inv = 5'd11;
            5'd21:   inv = 5'd5;
            5'd23:   inv = 5'd17;
            default: inv = 5'd25;
        endcase
        return inv;
    endfunction

endpackage

// ----- rtl/hill_cipher_2x2_stream.sv -----
// Top level of the 2x2 Hill cipher over a byte stream.
//
//   Channel   Handshake                   Payload
//   input     push / full                 i_item   (symbol, end_of_text)
//   result    empty / pop                 o_result (out_letter, pair_last, text_done)
//   config    psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// One item is accepted per cycle while full is low. Each pair passes the pair queue,
// the sum registers and the output registers and gives two result items, one per
// cycle while pop is high. After reset and after every register write, full stays
// high while the key pipeline derives the active matrix.
// Result stalls back up through a four-pair queue before full rises.
module hill_cipher_2x2_stream import hc2_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  t_in_item         i_item,
    output logic             empty,
    input  logic             pop,
    output t_out_item        o_result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready
);

    t_key  key;
    logic  key_busy, accept;
    logic  f_pair_valid, q_full, q_empty, q_pop;
    t_pair f_pair, q_pair;

    assign pready = 1'b1;
    assign full   = key_busy | q_full;
    assign accept = push & ~full;

    hc2_keygen u_keygen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_key     (key),
        .o_busy    (key_busy)
    );

    hc2_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_item       (i_item),
        .i_pad        (key.pad),
        .o_pair_valid (f_pair_valid),
        .o_pair       (f_pair)
    );

    hc2_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_pair_valid),
        .i_data  (f_pair),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_pair),
        .o_empty (q_empty)
    );

    hc2_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key        (key),
        .i_pair_valid (~q_empty),
        .i_pair       (q_pair),
        .o_pair_pop   (q_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_result     (o_result)
    );

endmodule

// ----- rtl/hc2_keygen.sv -----
// Configuration registers and the pipelined derivation of the active key matrix.
module hc2_keygen import hc2_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_psel,
    input  logic             i_penable,
    input  logic             i_pwrite,
    input  logic [AddrW-1:0] i_paddr,
    input  logic [DataW-1:0] i_pwdata,
    output logic [DataW-1:0] o_prdata,
    output t_key             o_key,
    output logic             o_busy
);

    logic [RegIdxW-1:0] reg_idx;
    logic               wr;
    t_letter            r_a11, r_a12, r_a21, r_a22, r_pad_cfg;
    logic               r_dir;
    logic [KeyLatW-1:0] r_busy;
    t_letter            a, b, c, d;
    logic [9:0]         r_ad, r_cb;
    t_letter            r_det, r_f;
    logic [9:0]         r_fp11, r_fp12, r_fp21, r_fp22;
    t_key               r_key;

    assign reg_idx = i_paddr[AddrW-1:2];
    assign wr      = i_psel & i_penable & i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a11     <= 5'd1;
            r_a12     <= 5'd0;
            r_a21     <= 5'd0;
            r_a22     <= 5'd1;
            r_dir     <= 1'b0;
            r_pad_cfg <= 5'd16;
            r_busy    <= KeyLatW'(KeyLatency);
        end else begin
            if (wr) begin
                unique case (reg_idx)
                    RegKeyA11:    r_a11     <= i_pwdata[4:0];
                    RegKeyA12:    r_a12     <= i_pwdata[4:0];
                    RegKeyA21:    r_a21     <= i_pwdata[4:0];
                    RegKeyA22:    r_a22     <= i_pwdata[4:0];
                    RegDirection: r_dir     <= i_pwdata[0];
                    RegPadLetter: r_pad_cfg <= i_pwdata[4:0];
                    default: ;
                endcase
                r_busy <= KeyLatW'(KeyLatency);
            end else if (r_busy != '0) begin
                r_busy <= r_busy - 1'b1;
            end
        end
    end

    always_comb begin
        unique case (reg_idx)
            RegKeyA11:    o_prdata = DataW'(r_a11);
            RegKeyA12:    o_prdata = DataW'(r_a12);
            RegKeyA21:    o_prdata = DataW'(r_a21);
            RegKeyA22:    o_prdata = DataW'(r_a22);
            RegDirection: o_prdata = DataW'(r_dir);
            RegPadLetter: o_prdata = DataW'(r_pad_cfg);
            default:      o_prdata = '0;
        endcase
    end

    assign a = f_red26(r_a11);
    assign b = f_red26(r_a12);
    assign c = f_red26(r_a21);
    assign d = f_red26(r_a22);

    always_ff @(posedge i_clk) begin
        r_ad   <= 10'(a) * 10'(d);
        r_cb   <= 10'(c) * 10'(b);
        r_det  <= f_mod26(11'(r_ad) + 11'(Modulus * Modulus) - 11'(r_cb));
        r_f    <= f_inv26(r_det);
        r_fp11 <= 10'(r_f) * 10'(d);
        r_fp12 <= 10'(r_f) * 10'(f_neg26(b));
        r_fp21 <= 10'(r_f) * 10'(f_neg26(c));
        r_fp22 <= 10'(r_f) * 10'(a);
        r_key.m11 <= r_dir ? f_mod26(11'(r_fp11)) : a;
        r_key.m12 <= r_dir ? f_mod26(11'(r_fp12)) : b;
        r_key.m21 <= r_dir ? f_mod26(11'(r_fp21)) : c;
        r_key.m22 <= r_dir ? f_mod26(11'(r_fp22)) : d;
        r_key.pad <= f_red26(r_pad_cfg);
    end

    assign o_key  = r_key;
    assign o_busy = (r_busy != '0);

endmodule

// ----- rtl/hc2_front.sv -----
// Front end: folds case, drops non-letters and forms letter pairs with padding.
module hc2_front import hc2_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    input  t_letter  i_pad,
    output logic     o_pair_valid,
    output t_pair    o_pair
);

    logic    is_upper, is_lower, is_letter, eot;
    t_letter letter;
    logic    r_held_valid, n_held_valid;
    t_letter r_held_letter, n_held_letter;

    assign is_upper  = (i_item.symbol >= UpperA) && (i_item.symbol <= UpperZ);
    assign is_lower  = (i_item.symbol >= LowerA) && (i_item.symbol <= LowerZ);
    assign is_letter = is_upper | is_lower;
    assign eot       = i_item.end_of_text;
    assign letter    = is_upper ? 5'(i_item.symbol - UpperA) : 5'(i_item.symbol - LowerA);

    always_comb begin
        n_held_valid  = r_held_valid;
        n_held_letter = r_held_letter;
        o_pair_valid  = 1'b0;
        o_pair.p1     = r_held_letter;
        o_pair.p2     = letter;
        o_pair.last   = eot;
        if (i_accept) begin
            if (is_letter && r_held_valid) begin
                o_pair_valid  = 1'b1;
                n_held_valid  = 1'b0;
                n_held_letter = '0;
            end else if (is_letter && eot) begin
                o_pair_valid = 1'b1;
                o_pair.p1    = letter;
                o_pair.p2    = i_pad;
                o_pair.last  = 1'b1;
            end else if (is_letter) begin
                n_held_valid  = 1'b1;
                n_held_letter = letter;
            end else if (eot && r_held_valid) begin
                o_pair_valid  = 1'b1;
                o_pair.p2     = i_pad;
                o_pair.last   = 1'b1;
                n_held_valid  = 1'b0;
                n_held_letter = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid  <= 1'b0;
            r_held_letter <= '0;
        end else begin
            r_held_valid  <= n_held_valid;
            r_held_letter <= n_held_letter;
        end
    end

endmodule

// ----- rtl/hc2_fifo.sv -----
// Short queue of letter pairs between the front end and the cipher back end.
module hc2_fifo import hc2_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_pair i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_pair o_data,
    output logic  o_empty
);

    t_pair            r_mem [QDepth];
    logic [QPtrW-1:0] r_wr, r_rd;
    logic [QCntW-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == QCntW'(QDepth));
    assign o_empty = (r_count == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- rtl/hc2_back.sv -----
// Back end: multiplies each pair by the key, reduces mod 26 and hands out two letters.
module hc2_back import hc2_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_key      i_key,
    input  logic      i_pair_valid,
    input  t_pair     i_pair,
    output logic      o_pair_pop,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_result
);

    logic        r_s_valid, r_s_last;
    logic [10:0] r_s1, r_s2;
    logic        r_o_valid, r_o_half, r_o_last;
    t_letter     r_o_c1, r_o_c2;
    logic        out_free, s_adv, s_ready;

    assign out_free   = ~r_o_valid | (i_pop & r_o_half);
    assign s_adv      = r_s_valid & out_free;
    assign s_ready    = ~r_s_valid | s_adv;
    assign o_pair_pop = i_pair_valid & s_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_o_half  <= 1'b0;
        end else begin
            if (s_ready) begin
                r_s_valid <= i_pair_valid;
            end
            if (s_adv) begin
                r_o_valid <= 1'b1;
                r_o_half  <= 1'b0;
            end else if (i_pop && r_o_valid) begin
                if (r_o_half) begin
                    r_o_valid <= 1'b0;
                end else begin
                    r_o_half <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pair_pop) begin
            r_s1     <= 11'(10'(i_pair.p1) * 10'(i_key.m11)) + 11'(10'(i_pair.p2) * 10'(i_key.m21));
            r_s2     <= 11'(10'(i_pair.p1) * 10'(i_key.m12)) + 11'(10'(i_pair.p2) * 10'(i_key.m22));
            r_s_last <= i_pair.last;
        end
        if (s_adv) begin
            r_o_c1   <= f_mod26(r_s1);
            r_o_c2   <= f_mod26(r_s2);
            r_o_last <= r_s_last;
        end
    end

    assign o_empty             = ~r_o_valid;
    assign o_result.out_letter = 7'(LetterBase) + 7'(r_o_half ? r_o_c2 : r_o_c1);
    assign o_result.pair_last  = r_o_half;
    assign o_result.text_done  = r_o_half & r_o_last;

endmodule

// ----- rtl/hc2_checker.sv -----
// Port-level checker for the Hill cipher stream, bound to the top level.
`include "hill_cipher_2x2_stream_defines.svh"

module hc2_checker import hc2_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input t_out_item o_result,
    input logic      psel,
    input logic      penable,
    input logic      pwrite
);

    logic letter_ok;
    logic first_half;
    logic cfg_write;

    assign letter_ok  = (o_result.out_letter >= 7'(LetterBase)) &&
                        (o_result.out_letter <= 7'(LetterBase + Modulus - 1));
    assign first_half = !empty && !o_result.pair_last;
    assign cfg_write  = psel && penable && pwrite;

    `HC2_ASSERT_CLK(a_letter_range, i_clk, i_rst_n, !empty |-> letter_ok)
    `HC2_ASSERT_ALWAYS(a_done_on_second, i_clk, first_half |-> !o_result.text_done)
    `HC2_ASSERT_CLK(a_second_follows, i_clk, i_rst_n, (pop && first_half) |=> !empty)
    `HC2_ASSERT_CLK(a_stall_holds, i_clk, i_rst_n, (!empty && !pop) |=> $stable(o_result))
    `HC2_ASSERT_CLK(a_cfg_blocks_input, i_clk, i_rst_n, cfg_write |=> full)

endmodule

bind hill_cipher_2x2_stream hc2_checker u_hc2_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite)
);

// ----- verif/hill_cipher_2x2_stream_checker.sv -----
// Checker for the Hill cipher stream: tracks key writes, predicts the letters and compares them.
module hill_cipher_2x2_stream_checker import hc2_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic             i_full,
    input  t_in_item         i_item,
    input  logic             i_empty,
    input  logic             i_pop,
    input  t_out_item        i_result,
    input  logic             i_psel,
    input  logic             i_penable,
    input  logic             i_pwrite,
    input  logic             i_pready,
    input  logic [AddrW-1:0] i_paddr,
    input  logic [DataW-1:0] i_pwdata,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_letters_checked
);

    t_letter   key11, key12, key21, key22, pad;
    logic      decrypt;
    t_letter   held_letter;
    logic      held_valid;
    t_out_item expected_letters[$];
    int        fails;
    int        checked;

    function automatic int inverse_factor(input int det);
        for (int i = 0; i < 26; i++) begin
            if ((det * i) % 26 == 1) begin
                return i;
            end
        end
        return 25;
    endfunction

    function automatic void encipher_pair(input int p1, input int p2, input logic last);
        int a, b, c, d, det, f, m11, m12, m21, m22, c1, c2;
        a = key11 % 26;
        b = key12 % 26;
        c = key21 % 26;
        d = key22 % 26;
        if (decrypt) begin
            det = (a * d + (26 - (c * b) % 26)) % 26;
            f   = inverse_factor(det);
            m11 = (f * d) % 26;
            m12 = (f * ((26 - b) % 26)) % 26;
            m21 = (f * ((26 - c) % 26)) % 26;
            m22 = (f * a) % 26;
        end else begin
            m11 = a;
            m12 = b;
            m21 = c;
            m22 = d;
        end
        c1 = (p1 * m11 + p2 * m21) % 26;
        c2 = (p1 * m12 + p2 * m22) % 26;
        expected_letters.push_back('{out_letter: 7'(c1 + LetterBase), pair_last: 1'b0,
                                     text_done: 1'b0});
        expected_letters.push_back('{out_letter: 7'(c2 + LetterBase), pair_last: 1'b1,
                                     text_done: last});
    endfunction

    always @(posedge i_clk) begin
        t_out_item exp_item;
        logic [7:0] sym;
        logic       is_letter;
        if (!i_rst_n) begin
            key11       = 5'd1;
            key12       = 5'd0;
            key21       = 5'd0;
            key22       = 5'd1;
            decrypt     = 1'b0;
            pad         = 5'd16;
            held_letter = '0;
            held_valid  = 1'b0;
            fails       = 0;
            checked     = 0;
            expected_letters.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[AddrW-1:2])
                    RegKeyA11:    key11   = i_pwdata[4:0];
                    RegKeyA12:    key12   = i_pwdata[4:0];
                    RegKeyA21:    key21   = i_pwdata[4:0];
                    RegKeyA22:    key22   = i_pwdata[4:0];
                    RegDirection: decrypt = i_pwdata[0];
                    RegPadLetter: pad     = i_pwdata[4:0];
                    default: ;
                endcase
            end
            if (!i_empty && i_pop) begin
                checked++;
                if (expected_letters.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result letter=%h pair_last=%b text_done=%b",
                             $time, i_result.out_letter, i_result.pair_last,
                             i_result.text_done);
                end else begin
                    exp_item = expected_letters.pop_front();
                    if (i_result.out_letter !== exp_item.out_letter ||
                        i_result.pair_last !== exp_item.pair_last ||
                        i_result.text_done !== exp_item.text_done) begin
                        fails++;
                        $display("%0t: expected letter=%h pair_last=%b text_done=%b, %s",
                                 $time, exp_item.out_letter, exp_item.pair_last,
                                 exp_item.text_done, "got");
                        $display("%0t:      got letter=%h pair_last=%b text_done=%b",
                                 $time, i_result.out_letter, i_result.pair_last,
                                 i_result.text_done);
                    end
                end
            end
            if (i_push && !i_full) begin
                sym = i_item.symbol;
                if (sym >= UpperA && sym <= UpperZ) begin
                    sym = sym + 8'd32;
                end
                is_letter = (sym >= LowerA && sym <= LowerZ);
                if (is_letter && held_valid) begin
                    encipher_pair(held_letter, sym - LowerA, i_item.end_of_text);
                    held_valid  = 1'b0;
                    held_letter = '0;
                end else begin
                    if (is_letter) begin
                        held_letter = 5'(sym - LowerA);
                        held_valid  = 1'b1;
                    end
                    if (i_item.end_of_text && held_valid) begin
                        encipher_pair(held_letter, pad, 1'b1);
                        held_valid  = 1'b0;
                        held_letter = '0;
                    end
                end
            end
        end
        o_pending         <= expected_letters.size();
        o_fail_count      <= fails + expected_letters.size() * 0;
        o_letters_checked <= checked;
    end

endmodule

// ----- verif/tb.sv -----
// Testbench top for the Hill cipher stream: drives texts and key writes, gives the verdict.
module tb;
    import hc2_pkg::*;

    logic             clk     = 1'b0;
    logic             rst_n   = 1'b0;
    logic             push    = 1'b0;
    logic             pop     = 1'b0;
    logic             psel    = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite  = 1'b0;
    logic [AddrW-1:0] paddr   = '0;
    logic [DataW-1:0] pwdata  = '0;
    t_in_item         item    = '0;
    logic             full;
    logic             empty;
    logic             pready;
    logic [DataW-1:0] prdata;
    t_out_item        result;

    int fail_count;
    int pending;
    int letters_checked;
    int idle_pct  = 0;
    int stall_pct = 0;
    int bytes_sent = 0;
    int letters_sent = 0;
    int texts_sent = 0;
    int key_settings = 1;

    logic [8:0] directed [17] = '{
        {8'h41, 1'b0}, {8'h7A, 1'b0},
        {8'h5A, 1'b0}, {8'h61, 1'b1},
        {8'h00, 1'b0}, {8'hFF, 1'b0}, {8'h40, 1'b0},
        {8'h5B, 1'b0}, {8'h60, 1'b0}, {8'h7B, 1'b0},
        {8'h6D, 1'b1},
        {8'h6B, 1'b0}, {8'h80, 1'b1},
        {8'h20, 1'b1},
        {8'h51, 1'b0}, {8'h62, 1'b0}, {8'h43, 1'b1}
    };

    hill_cipher_2x2_stream dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .push     (push),
        .full     (full),
        .i_item   (item),
        .empty    (empty),
        .pop      (pop),
        .o_result (result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    hill_cipher_2x2_stream_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_push            (push),
        .i_full            (full),
        .i_item            (item),
        .i_empty           (empty),
        .i_pop             (pop),
        .i_result          (result),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_pready          (pready),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_letters_checked (letters_checked)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        pop <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        #5000000;
        $display("FAIL hill_cipher_2x2_stream");
        $finish;
    end

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= UpperA && b <= UpperZ) || (b >= LowerA && b <= LowerZ);
    endfunction

    task automatic send_byte(input logic [7:0] sym, input logic eot);
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= '{symbol: sym, end_of_text: eot};
        do @(posedge clk); while (full);
        bytes_sent++;
        if (is_letter(sym) || eot) begin
            letters_sent++;
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [RegIdxW-1:0] idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DataW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic load_key(input int a11, input int a12, input int a21, input int a22,
                            input int dir, input int pad);
        write_reg(RegKeyA11, a11);
        write_reg(RegKeyA12, a12);
        write_reg(RegKeyA21, a21);
        write_reg(RegKeyA22, a22);
        write_reg(RegDirection, dir);
        write_reg(RegPadLetter, pad);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        key_settings++;
    endtask

    task automatic send_text();
        int         len;
        logic [7:0] b;
        len = $urandom_range(14, 1);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 85) begin
                b = ($urandom_range(1) ? UpperA : LowerA) + 8'($urandom_range(25));
            end else begin
                do b = 8'($urandom_range(255)); while (is_letter(b));
            end
            send_byte(b, i == len - 1);
        end
        texts_sent++;
    endtask

    initial begin
        int phase_start;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Identity key after reset: case folding, dropped bytes and the padding cases.
        foreach (directed[i]) begin
            send_byte(directed[i][8:1], directed[i][0]);
        end
        texts_sent += 5;
        wait_drained();

        for (int phase = 1; phase <= 12; phase++) begin
            case (phase)
                1: load_key(3, 3, 2, 5, 0, 23);
                2: load_key(3, 3, 2, 5, 1, 23);
                3: load_key(0, 0, 0, 0, 1, 0);
                4: load_key(25, 25, 25, 25, 0, 25);
                5: load_key(25, 25, 25, 25, 1, 25);
                6: load_key(1, 0, 0, 1, 1, 16);
                default: load_key($urandom_range(25), $urandom_range(25), $urandom_range(25),
                                  $urandom_range(25), $urandom_range(1), $urandom_range(25));
            endcase
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 88; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 88; end
                default: begin idle_pct = 35; stall_pct = 35; end
            endcase
            phase_start = letters_sent;
            while (letters_sent - phase_start < 52) begin
                send_text();
                if ($urandom_range(24) == 0) begin
                    wait_drained();
                end
            end
            wait_drained();
        end

        $display("Sent %0d bytes in %0d texts under %0d key settings, encrypt and decrypt.",
                 bytes_sent, texts_sent, key_settings);
        $display("Checked %0d result letters.", letters_checked);
        if (fail_count == 0) begin
            $display("PASS hill_cipher_2x2_stream");
        end else begin
            $display("FAIL hill_cipher_2x2_stream");
        end
        $finish;
    end

endmodule
